// File: rtl/largest_cluster_periodic_grid_core_macros.svh
// Assertion macros for the largest-cluster lattice core.
// Included by the RTL files that carry concurrent assertions.
`ifndef LARGEST_CLUSTER_PERIODIC_GRID_CORE_MACROS_SVH
`define LARGEST_CLUSTER_PERIODIC_GRID_CORE_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define LCPG_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication under synchronous reset.
`define LCPG_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

// File: rtl/lcpg_pkg.sv
// Shared types and constants for the largest-cluster lattice core.
// No dependencies.
package lcpg_pkg;

  localparam int OUT_W = 13;
  localparam int CFG_W = 7;
  localparam int SIDE_RST = 64;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_NB_RD,
    ST_NB_CHK,
    ST_FIN
  } lcpg_state_t;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_LEFT,
    DIR_DOWN,
    DIR_UP
  } lcpg_dir_t;

  typedef struct packed {
    logic lat_we;
    logic lat_d;
    logic vis_we;
    logic vis_d;
  } lcpg_bm_wr_t;

endpackage

// File: rtl/lcpg_bitmap.sv
// Site bitmap and visited bitmap, one write and one registered read each cycle.
// Depends on lcpg_pkg.
module lcpg_bitmap import lcpg_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  lcpg_bm_wr_t   wr,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] raddr,
  output logic          lat_q,
  output logic          vis_q
);

  logic lat_mem [DEPTH];
  logic vis_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.lat_we) begin
      lat_mem[waddr] <= wr.lat_d;
    end
    lat_q <= lat_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.vis_we) begin
      vis_mem[waddr] <= wr.vis_d;
    end
    vis_q <= vis_mem[raddr];
  end

endmodule

// File: rtl/lcpg_stack.sv
// Search stack memory holding row and column of sites awaiting expansion.
// Depends on lcpg_pkg.
module lcpg_stack import lcpg_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lcpg_nbr.sv
// Periodic neighbor unit: wraps row/column one step and forms the site address.
// Depends on lcpg_pkg.
module lcpg_nbr import lcpg_pkg::*; #(
  parameter int SW = 6,
  parameter int LW = 7,
  parameter int AW = 12,
  parameter int NW = 13
) (
  input  logic [SW-1:0] row,
  input  logic [SW-1:0] col,
  input  lcpg_dir_t     dir,
  input  logic [LW-1:0] side,
  output logic [SW-1:0] trow,
  output logic [SW-1:0] tcol,
  output logic [AW-1:0] taddr
);

  logic          col_hi;
  logic          row_hi;
  logic [SW-1:0] side_m1;
  logic [NW-1:0] prod;

  assign col_hi  = (LW'(col) + LW'(1)) == side;
  assign row_hi  = (LW'(row) + LW'(1)) == side;
  assign side_m1 = SW'(side - LW'(1));

  always_comb begin
    trow = row;
    tcol = col;
    case (dir)
      DIR_RIGHT: tcol = col_hi ? '0 : col + SW'(1);
      DIR_LEFT:  tcol = (col == '0) ? side_m1 : col - SW'(1);
      DIR_DOWN:  trow = row_hi ? '0 : row + SW'(1);
      DIR_UP:    trow = (row == '0) ? side_m1 : row - SW'(1);
      default:   tcol = col;
    endcase
  end

  assign prod  = NW'(trow) * NW'(side) + NW'(tcol);
  assign taddr = prod[AW-1:0];

endmodule

// File: rtl/largest_cluster_periodic_grid_core.sv
// Largest 4-connected cluster of up sites on a periodic L x L lattice.
// Top level: sequencer around lcpg_bitmap, lcpg_stack and lcpg_nbr; uses lcpg_pkg.
//
// Usage:
//   Sites arrive on in_valid/in_ready, one bit per transfer, row-major.
//   cfg_we/cfg_side_length set L (clamped to 2..MAX_SIDE) and restart the
//   frame at site 0; write only while the core is idle.
//   During loading in_ready is high and each site is taken as it is offered.
//   After the last site the core searches with a depth-first walk and
//   holds in_ready low. Each scanned site is read and then checked; each
//   visited up site is popped, its stack entry read, and its four neighbors
//   probed, each with a read and a check through the single bitmap read
//   port; a pop of the empty stack closes each cluster before the result is posted.
//   The visited map is cleared site by site while the frame loads.
//   One result per frame is held in an output register on out_valid; the
//   next frame loads while it waits. A second result waits until the
//   receiver takes the first. Reset sets L to 64 (or MAX_SIDE if smaller),
//   empties the frame and drops any pending result.
module largest_cluster_periodic_grid_core import lcpg_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_site_up,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_largest_cluster,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_side_length
);

`include "largest_cluster_periodic_grid_core_macros.svh"

  localparam int N     = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (N > 1) ? $clog2(N) : 1;
  localparam int NW    = $clog2(N + 1);
  localparam int SW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int LW    = $clog2(MAX_SIDE + 1);
  localparam int CMPW  = (LW > CFG_W) ? LW : CFG_W;
  localparam int L_RST = (SIDE_RST > MAX_SIDE) ? MAX_SIDE : SIDE_RST;
  localparam int N_RST = L_RST * L_RST;

  lcpg_state_t state_r, state_nxt;

  logic [LW-1:0]    side_r, side_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    s_r, s_nxt;
  logic [SW-1:0]    srow_r, srow_nxt;
  logic [SW-1:0]    scol_r, scol_nxt;
  logic [SW-1:0]    crow_r, crow_nxt;
  logic [SW-1:0]    ccol_r, ccol_nxt;
  logic [SW-1:0]    trow_r, trow_nxt;
  logic [SW-1:0]    tcol_r, tcol_nxt;
  logic [AW-1:0]    taddr_r, taddr_nxt;
  lcpg_dir_t        dir_r, dir_nxt;
  logic [NW-1:0]    top_r, top_nxt;
  logic [NW-1:0]    size_r, size_nxt;
  logic [NW-1:0]    best_r, best_nxt;
  logic             bond_r, bond_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic [CMPW-1:0]  cfg_ext;
  logic [LW-1:0]    cfg_side;
  logic             load_last;
  logic             scan_last;
  logic             scan_col_hi;
  logic             start_walk;
  logic             out_free;

  lcpg_bm_wr_t      bm_wr;
  logic [AW-1:0]    bm_waddr;
  logic [AW-1:0]    bm_raddr;
  logic             lat_q;
  logic             vis_q;
  logic             stk_we;
  logic [AW-1:0]    stk_waddr;
  logic [2*SW-1:0]  stk_wdata;
  logic [AW-1:0]    stk_raddr;
  logic [2*SW-1:0]  stk_q;
  logic [SW-1:0]    nb_row;
  logic [SW-1:0]    nb_col;
  logic [AW-1:0]    nb_addr;

  lcpg_bitmap #(.DEPTH(N), .AW(AW)) u_bitmap (
    .clk   (clk),
    .wr    (bm_wr),
    .waddr (bm_waddr),
    .raddr (bm_raddr),
    .lat_q (lat_q),
    .vis_q (vis_q)
  );

  lcpg_stack #(.DEPTH(N), .AW(AW), .DW(2 * SW)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  lcpg_nbr #(.SW(SW), .LW(LW), .AW(AW), .NW(NW)) u_nbr (
    .row   (crow_r),
    .col   (ccol_r),
    .dir   (dir_r),
    .side  (side_r),
    .trow  (nb_row),
    .tcol  (nb_col),
    .taddr (nb_addr)
  );

  assign cfg_ext     = CMPW'(cfg_side_length);
  assign cfg_side    = (cfg_ext < CMPW'(2)) ? LW'(2) :
                       (cfg_ext > CMPW'(MAX_SIDE)) ? LW'(MAX_SIDE) : LW'(cfg_ext);
  assign load_last   = (NW'(cnt_r) + NW'(1)) == n_r;
  assign scan_last   = (NW'(s_r) + NW'(1)) == n_r;
  assign scan_col_hi = (LW'(scol_r) + LW'(1)) == side_r;
  assign start_walk  = lat_q && !vis_q;
  assign out_free    = !out_valid_r || out_ready;

  assign in_ready            = (state_r == ST_LOAD);
  assign out_valid           = out_valid_r;
  assign out_largest_cluster = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:     if (in_valid && load_last && !cfg_we) state_nxt = ST_SCAN_RD;
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (start_walk) begin
          state_nxt = ST_POP;
        end else begin
          state_nxt = scan_last ? ST_FIN : ST_SCAN_RD;
        end
      end
      ST_POP: begin
        if (top_r != '0) begin
          state_nxt = ST_POP_WAIT;
        end else begin
          state_nxt = scan_last ? ST_FIN : ST_SCAN_RD;
        end
      end
      ST_POP_WAIT: state_nxt = ST_NB_RD;
      ST_NB_RD:    state_nxt = ST_NB_CHK;
      ST_NB_CHK:   state_nxt = (dir_r == DIR_UP) ? ST_POP : ST_NB_RD;
      ST_FIN:      if (out_free) state_nxt = ST_LOAD;
      default:     state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    side_nxt      = side_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    s_nxt         = s_r;
    srow_nxt      = srow_r;
    scol_nxt      = scol_r;
    crow_nxt      = crow_r;
    ccol_nxt      = ccol_r;
    trow_nxt      = trow_r;
    tcol_nxt      = tcol_r;
    taddr_nxt     = taddr_r;
    dir_nxt       = dir_r;
    top_nxt       = top_r;
    size_nxt      = size_r;
    best_nxt      = best_r;
    bond_nxt      = bond_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    bm_wr         = '0;
    bm_waddr      = cnt_r;
    bm_raddr      = s_r;
    stk_we        = 1'b0;
    stk_waddr     = AW'(top_r);
    stk_wdata     = {trow_r, tcol_r};
    stk_raddr     = AW'(top_r - NW'(1));
    case (state_r)
      ST_LOAD: begin
        if (cfg_we) begin
          side_nxt = cfg_side;
          n_nxt    = NW'(cfg_side) * NW'(cfg_side);
          cnt_nxt  = '0;
        end else if (in_valid) begin
          bm_wr.lat_we = 1'b1;
          bm_wr.lat_d  = in_site_up;
          bm_wr.vis_we = 1'b1;
          bm_wr.vis_d  = 1'b0;
          cnt_nxt      = load_last ? '0 : cnt_r + AW'(1);
          if (load_last) begin
            s_nxt    = '0;
            srow_nxt = '0;
            scol_nxt = '0;
            best_nxt = '0;
            bond_nxt = 1'b0;
          end
        end
      end
      ST_SCAN_CHK: begin
        if (start_walk) begin
          bm_wr.vis_we = 1'b1;
          bm_wr.vis_d  = 1'b1;
          bm_waddr     = s_r;
          stk_we       = 1'b1;
          stk_waddr    = '0;
          stk_wdata    = {srow_r, scol_r};
          top_nxt      = NW'(1);
          size_nxt     = NW'(1);
        end else begin
          s_nxt    = s_r + AW'(1);
          scol_nxt = scan_col_hi ? '0 : scol_r + SW'(1);
          srow_nxt = scan_col_hi ? srow_r + SW'(1) : srow_r;
        end
      end
      ST_POP: begin
        if (top_r != '0) begin
          top_nxt = top_r - NW'(1);
        end else begin
          if (size_r > best_r) best_nxt = size_r;
          s_nxt    = s_r + AW'(1);
          scol_nxt = scan_col_hi ? '0 : scol_r + SW'(1);
          srow_nxt = scan_col_hi ? srow_r + SW'(1) : srow_r;
        end
      end
      ST_POP_WAIT: begin
        crow_nxt = stk_q[2*SW-1:SW];
        ccol_nxt = stk_q[SW-1:0];
        dir_nxt  = DIR_RIGHT;
      end
      ST_NB_RD: begin
        bm_raddr  = nb_addr;
        trow_nxt  = nb_row;
        tcol_nxt  = nb_col;
        taddr_nxt = nb_addr;
      end
      ST_NB_CHK: begin
        if (lat_q) begin
          bond_nxt = 1'b1;
          if (!vis_q) begin
            bm_wr.vis_we = 1'b1;
            bm_wr.vis_d  = 1'b1;
            bm_waddr     = taddr_r;
            stk_we       = 1'b1;
            top_nxt      = top_r + NW'(1);
            size_nxt     = size_r + NW'(1);
          end
        end
        dir_nxt = lcpg_dir_t'(2'(dir_r) + 2'd1);
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = bond_r ? OUT_W'(best_r) : '0;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      side_r      <= LW'(L_RST);
      n_r         <= NW'(N_RST);
      cnt_r       <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    srow_r     <= srow_nxt;
    scol_r     <= scol_nxt;
    crow_r     <= crow_nxt;
    ccol_r     <= ccol_nxt;
    trow_r     <= trow_nxt;
    tcol_r     <= tcol_nxt;
    taddr_r    <= taddr_nxt;
    dir_r      <= dir_nxt;
    size_r     <= size_nxt;
    best_r     <= best_nxt;
    bond_r     <= bond_nxt;
    out_data_r <= out_data_nxt;
  end

  `LCPG_ASSERT_NOW(a_stack_bound, stk_we && (state_r == ST_NB_CHK), top_r < NW'(N), "stack push beyond depth")
  `LCPG_ASSERT_NOW(a_load_bound, state_r == ST_LOAD, NW'(cnt_r) < n_r, "load counter past frame end")
  `LCPG_ASSERT_NOW(a_size_bound, state_r == ST_POP, size_r <= n_r, "cluster larger than lattice")
  `LCPG_ASSERT_NEXT(a_fin_out, (state_r == ST_FIN) && out_free, out_valid && (state_r == ST_LOAD), "result not posted on frame end")

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for largest_cluster_periodic_grid_core: streams lattice frames, predicts the
// largest periodic cluster of each frame and checks every result in order.
// Depends on lcpg_pkg and the core RTL only.
module tb_top;
  import lcpg_pkg::*;

  localparam int MAX_SIDE = 64;
  localparam int MAX_SITES = MAX_SIDE * MAX_SIDE;
  localparam int CYCLE_LIMIT = 1000000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_site_up = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OUT_W-1:0] out_largest_cluster;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_side_length = '0;

  largest_cluster_periodic_grid_core #(.MAX_SIDE(MAX_SIDE)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_site_up          (in_site_up),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_largest_cluster (out_largest_cluster),
    .cfg_we              (cfg_we),
    .cfg_side_length     (cfg_side_length)
  );

  logic             site_queue [$];
  logic [OUT_W-1:0] cluster_sizes [$];
  bit               site_map [0:MAX_SITES-1];
  bit               visit_map [0:MAX_SITES-1];
  int               walk_stack [0:MAX_SITES-1];

  logic [CFG_W-1:0] side_reg;
  int               frame_fill;
  int               sites_pushed = 0;
  int               sites_taken = 0;
  int               frames_pushed = 0;
  int               results_seen = 0;
  int               side_writes = 0;
  int               errors = 0;
  int               idle_pct = 28;
  int               cycle_count = 0;
  logic             in_took = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic int eff_side(input logic [CFG_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > MAX_SIDE) return MAX_SIDE;
    return int'(raw);
  endfunction

  function automatic logic [OUT_W-1:0] largest_cluster_of(input int side);
    int n, top, s, u, t, k, cur, best;
    bit bond;
    lcpg_dir_t dir;
    n = side * side;
    best = 0;
    bond = 1'b0;
    for (s = 0; s < n; s++) visit_map[s] = 1'b0;
    for (s = 0; s < n; s++) begin
      if (site_map[s] && !visit_map[s]) begin
        visit_map[s] = 1'b1;
        cur = 1;
        walk_stack[0] = s;
        top = 1;
        while (top > 0) begin
          top--;
          u = walk_stack[top];
          for (k = 0; k < 4; k++) begin
            dir = lcpg_dir_t'(k);
            case (dir)
              DIR_RIGHT: t = (u / side) * side + (u % side + 1) % side;
              DIR_LEFT:  t = (u / side) * side + (u % side + side - 1) % side;
              DIR_DOWN:  t = (u + side) % n;
              default:   t = (u + n - side) % n;
            endcase
            if (site_map[t]) begin
              bond = 1'b1;
              if (!visit_map[t]) begin
                visit_map[t] = 1'b1;
                cur++;
                walk_stack[top] = t;
                top++;
              end
            end
          end
        end
        if (cur > best) best = cur;
      end
    end
    return bond ? OUT_W'(best) : '0;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (site_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid   <= 1'b1;
          in_site_up <= site_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin : watch
    int n;
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      in_took    <= 1'b0;
      side_reg   = CFG_W'(SIDE_RST);
      frame_fill = 0;
    end else begin
      in_took <= in_valid && in_ready;
      if (cfg_we) begin
        side_reg   = cfg_side_length;
        frame_fill = 0;
      end
      if (in_valid && in_ready) begin
        n = eff_side(side_reg) * eff_side(side_reg);
        if (frame_fill >= n) frame_fill = 0;
        site_map[frame_fill] = in_site_up;
        frame_fill++;
        sites_taken++;
        if (frame_fill == n) begin
          frame_fill = 0;
          cluster_sizes.push_back(largest_cluster_of(eff_side(side_reg)));
        end
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (cluster_sizes.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual %0d",
                   $time, out_largest_cluster);
        end else begin
          want = cluster_sizes.pop_front();
          if (out_largest_cluster !== want) begin
            errors++;
            $display("%0t: largest_cluster mismatch, expected %0d, actual %0d",
                     $time, want, out_largest_cluster);
          end
        end
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (!(sites_taken == sites_pushed && cluster_sizes.size() == 0));
    repeat (2 * eff_side(side_reg) * eff_side(side_reg) + 32) @(negedge clk);
  endtask

  task automatic write_side(input logic [CFG_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we          <= 1'b1;
    cfg_side_length <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    side_writes++;
  endtask

  task automatic queue_pattern(input int count, input logic [3:0] bits);
    for (int i = 0; i < count; i++) site_queue.push_back(bits[i]);
    sites_pushed += count;
  endtask

  task automatic queue_sites(input int count, input int density);
    for (int i = 0; i < count; i++) site_queue.push_back($urandom_range(0, 99) < density);
    sites_pushed += count;
  endtask

  initial begin
    int side, n, pick, density, rand_sites, rand_frames;
    rand_sites  = 0;
    rand_frames = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    write_side(2);
    queue_pattern(4, 4'b1111);
    queue_pattern(4, 4'b0000);
    queue_pattern(4, 4'b0001);
    queue_pattern(4, 4'b0011);
    // drop a half-loaded frame with the next write
    queue_pattern(2, 4'b0011);
    write_side(0);
    queue_pattern(4, 4'b1001);
    write_side(1);
    queue_pattern(4, 4'b1110);
    frames_pushed += 6;

    // load part of a clamped full-size frame, then drop it
    write_side(127);
    queue_sites(200, 59);

    while (rand_sites < 850) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) side = $urandom_range(0, 1);
      else if (pick < 55) side = $urandom_range(2, 4);
      else if (pick < 88) side = $urandom_range(5, 8);
      else side = $urandom_range(9, 16);
      write_side(CFG_W'(side));
      n = eff_side(CFG_W'(side)) * eff_side(CFG_W'(side));
      repeat ($urandom_range(1, 4)) begin
        idle_pct = (rand_frames >= 6 && rand_frames < 14) ? 0 : 28;
        pick = $urandom_range(0, 9);
        if (pick == 0) density = 0;
        else if (pick == 1) density = 100;
        else density = $urandom_range(20, 90);
        queue_sites(n, density);
        rand_frames++;
        rand_sites += n;
        frames_pushed++;
      end
      if ($urandom_range(0, 4) == 0) queue_sites($urandom_range(1, n - 1), 50);
    end
    idle_pct = 28;

    wait_idle();
    repeat (64) @(negedge clk);
    $display("run covered %0d sites in %0d frames across %0d side length writes",
             sites_taken, frames_pushed, side_writes);
    $display("%0d cluster sizes compared, %0d mismatches", results_seen, errors);
    if (errors == 0 && cluster_sizes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lcpg_pkg.sv
rtl/lcpg_bitmap.sv
rtl/lcpg_stack.sv
rtl/lcpg_nbr.sv
rtl/largest_cluster_periodic_grid_core.sv
bench/tb_top.sv
